// ===== sv/lpht_pkg.sv =====
`default_nettype none

package lpht_pkg;

	localparam int unsigned SIZE_W   = 7;
	localparam int unsigned KEY_W    = 16;
	localparam int unsigned SLOT_W   = 6;
	localparam int unsigned PROBE_W  = 7;
	localparam int unsigned STATUS_W = 2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd50;
	localparam logic [SIZE_W-1:0] SIZE_MAX   = 7'd127;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_FIND   = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_LOOK
	} back_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// ===== sv/lpht_req_if.sv =====
`default_nettype none

interface lpht_req_if;
	import lpht_pkg::*;

	logic              valid;
	logic              ready;
	logic              cmd;
	logic [KEY_W-1:0]  key;

	modport source (output valid, input ready, output cmd, output key);
	modport sink   (input valid, output ready, input cmd, input key);
endinterface

`default_nettype wire

// ===== sv/lpht_rsp_if.sv =====
`default_nettype none

interface lpht_rsp_if;
	import lpht_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot_index;
	logic [PROBE_W-1:0]  probe_count;

	modport source (output valid, input ready, output status, output slot_index,
		output probe_count);
	modport sink   (input valid, output ready, input status, input slot_index,
		input probe_count);
endinterface

`default_nettype wire

// ===== sv/linear_probe_hash_table_core.sv =====
`default_nettype none

// Channel  Dir  Payload                                     Item
// req      in   cmd (0 insert, 1 find), key[15:0]          one command
// rsp      out  status[1:0], slot_index[5:0], probe[6:0]   one result per command
// cfg      in   cfg_we, cfg_wdata[6:0]                      table size register
//
// The front takes one item at a time and accepts the next only after pushing the
// last: a restoring remainder unit finds key mod size one bit per cycle.
// The back walks an item's probe chain through the slots of the key RAM,
// one read port giving one slot per cycle; a two-entry queue sits between them.
// After reset the back clears every RAM entry; the front keeps
// accepting into the queue meanwhile.
// A stalled rsp holds its result; the front and the queue keep taking items until the queue is full.

module linear_probe_hash_table_core #(
	parameter int unsigned TABLE_DEPTH = 64,
	parameter int unsigned KEY_BITS    = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	lpht_req_if.sink                         req,
	lpht_rsp_if.source                       rsp,
	input  wire logic                        cfg_we,
	input  wire logic [lpht_pkg::SIZE_W-1:0] cfg_wdata
);
	import lpht_pkg::*;

	localparam int unsigned AW  = $clog2(TABLE_DEPTH);
	localparam int unsigned KW  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int unsigned EW  = 1 + KW + AW;
	// largest usable size: the RAM depth, or what the size register can hold
	localparam int unsigned CAP = (TABLE_DEPTH < 127) ? TABLE_DEPTH : 127;
	localparam logic [SIZE_W-1:0] CAP_SIZE = SIZE_W'(CAP);

	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] n;
	logic              push;
	logic [EW-1:0]     push_data;
	logic              pop;
	logic [EW-1:0]     head;
	q_stat_t           q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	// Clamp the size: zero acts as one, anything past the capacity saturates.
	always_comb begin
		if (size_q == '0) begin
			n = SIZE_W'(1);
		end else if (size_q > CAP_SIZE) begin
			n = CAP_SIZE;
		end else begin
			n = size_q;
		end
	end

	// Front: accept the command, work out the home slot, push to the queue.
	lpht_front #(
		.KW (KW),
		.AW (AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.n         (n),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	// Decouple the two halves so either one may stall alone.
	lpht_fifo #(
		.WIDTH (EW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (head),
		.stat      (q_stat)
	);

	// Back: walk the probe chain in the key RAM and register the result.
	lpht_back #(
		.KW    (KW),
		.DEPTH (TABLE_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.n      (n),
		.q_stat (q_stat),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// ===== sv/lpht_ram.sv =====
`default_nettype none

module lpht_ram #(
	parameter int unsigned WIDTH = 17,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== sv/lpht_fifo.sv =====
`default_nettype none

module lpht_fifo #(
	parameter int unsigned WIDTH = 24
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output      logic [WIDTH-1:0] pop_data,
	output      lpht_pkg::q_stat_t stat
);
	import lpht_pkg::*;

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign pop_data   = mem_q[rd_q];
	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);

endmodule

`default_nettype wire

// ===== sv/lpht_front.sv =====
`default_nettype none

module lpht_front #(
	parameter int unsigned KW = 16,
	parameter int unsigned AW = 6
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	lpht_req_if.sink                         req,
	input  wire logic [lpht_pkg::SIZE_W-1:0] n,
	input  wire lpht_pkg::q_stat_t           q_stat,
	output      logic                        push,
	output      logic [AW+KW:0]              push_data
);
	import lpht_pkg::*;

	localparam int unsigned CW = $clog2(KW + 1);
	localparam int unsigned PW = ((AW > SIZE_W) ? AW : SIZE_W) + 1;

	front_state_t       state_q;
	front_state_t       state_d;
	logic               cmd_q;
	logic [KW-1:0]      key_q;
	logic [KW-1:0]      sh_q;
	logic [SIZE_W-1:0]  rem_q;
	logic [CW-1:0]      cnt_q;
	logic               accept;
	logic [SIZE_W:0]    trial;
	logic [SIZE_W:0]    rem_next;
	logic [PW-1:0]      rem_pw;

	// one remainder bit per cycle, key MSB first
	assign trial    = {rem_q, sh_q[KW-1]};
	assign rem_next = (trial >= {1'b0, n}) ? trial - {1'b0, n} : trial;
	assign rem_pw   = PW'(rem_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE:  if (req.valid) state_d = F_DIV;
			F_DIV:   if (cnt_q == CW'(1)) state_d = F_PUSH;
			F_PUSH:  if (!q_stat.full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		push      = 1'b0;
		case (state_q)
			F_IDLE:  req.ready = 1'b1;
			F_PUSH:  push      = !q_stat.full;
			default: ;
		endcase
	end

	assign accept    = req.valid && req.ready;
	assign push_data = {cmd_q, key_q, rem_pw[AW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= CW'(KW);
			end else if (state_q == F_DIV) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.cmd;
			key_q <= req.key[KW-1:0];
			sh_q  <= req.key[KW-1:0];
			rem_q <= '0;
		end else if (state_q == F_DIV) begin
			sh_q  <= sh_q << 1;
			rem_q <= rem_next[SIZE_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== sv/lpht_back.sv =====
`default_nettype none

module lpht_back #(
	parameter int unsigned KW    = 16,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic [lpht_pkg::SIZE_W-1:0]          n,
	input  wire lpht_pkg::q_stat_t                    q_stat,
	input  wire logic [$clog2(DEPTH)+KW:0]            head,
	output      logic                                 pop,
	lpht_rsp_if.source                                rsp
);
	import lpht_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned PW = ((AW > SIZE_W) ? AW : SIZE_W) + 1;

	back_state_t         state_q;
	back_state_t         state_d;
	logic [AW-1:0]       clr_q;
	logic [AW-1:0]       pos_q;
	logic [PROBE_W-1:0]  probe_q;
	logic                cmd_q;
	logic [KW-1:0]       key_q;

	logic                out_valid_q;
	status_t             status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [PROBE_W-1:0]  probes_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [KW:0]         ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [KW:0]         ram_rdata;

	logic                slot_used;
	logic                match;
	logic                last;
	logic                is_find;
	logic [PW-1:0]       pos_inc;
	logic [PW-1:0]       pos_pw;
	logic [AW-1:0]       next_pos;
	logic                done;
	logic                res_load;
	status_t             res_status;
	logic [SLOT_W-1:0]   res_slot;
	logic [PROBE_W-1:0]  res_probes;

	lpht_ram #(
		.WIDTH (KW + 1),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign slot_used = ram_rdata[KW];
	assign match     = slot_used && (ram_rdata[KW-1:0] == key_q);
	assign last      = (probe_q == n);
	assign is_find   = (cmd_q == CMD_FIND);
	assign pos_pw    = PW'(pos_q);
	assign pos_inc   = pos_pw + PW'(1);
	assign next_pos  = (pos_inc == PW'(n)) ? '0 : pos_inc[AW-1:0];

	// probe ends on a free slot, a key hit on find, or after n slots
	assign done = !slot_used || (is_find && match) || last;

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = B_IDLE;
			B_IDLE:  if (pop) state_d = B_LOOK;
			B_LOOK:  if (done) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = pos_q;
		ram_wdata  = {1'b1, key_q};
		ram_raddr  = head[AW-1:0];
		res_load   = 1'b0;
		res_status = ST_OK;
		res_slot   = '0;
		res_probes = '0;
		case (state_q)
			B_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			B_IDLE: begin
				pop = !q_stat.empty && (!out_valid_q || rsp.ready);
			end
			B_LOOK: begin
				ram_raddr = next_pos;
				res_load  = done;
				if (!is_find) begin
					if (!slot_used) begin
						ram_we   = 1'b1;
						res_slot = pos_pw[SLOT_W-1:0];
					end else begin
						res_status = ST_FULL;
					end
				end else if (match) begin
					res_slot   = pos_pw[SLOT_W-1:0];
					res_probes = probe_q;
				end else begin
					res_status = ST_MISS;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q   <= head[AW+KW];
			key_q   <= head[AW +: KW];
			pos_q   <= head[AW-1:0];
			probe_q <= PROBE_W'(1);
		end else if (state_q == B_LOOK && !done) begin
			pos_q   <= next_pos;
			probe_q <= probe_q + PROBE_W'(1);
		end
		if (res_load) begin
			status_q <= res_status;
			slot_q   <= res_slot;
			probes_q <= res_probes;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.slot_index  = slot_q;
	assign rsp.probe_count = probes_q;

endmodule

`default_nettype wire
